// ===== design/ipv4v_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4v_pkg
// Types and constants of the IPv4 address-with-port text validator.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4v_pkg;

  // Character codes the parser looks for
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharNine  = 8'd57;
  localparam logic [7:0] CharDot   = 8'd46;
  localparam logic [7:0] CharColon = 8'd58;
  localparam logic [7:0] CharPlus  = 8'd43;
  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharTab   = 8'd9;
  localparam logic [7:0] CharCr    = 8'd13;

  // Limits
  localparam logic [9:0]  OctetMax = 10'd255;
  localparam logic [19:0] PortMax  = 20'd65535;
  localparam logic [16:0] PortSat  = 17'h10000;
  localparam logic [1:0]  LastGroup = 2'd3;
  localparam logic [1:0]  MaxDigits = 2'd3;

  // Port part phase, one-hot
  typedef enum logic [2:0] {
    PH_WAIT   = 3'b001,  // awaiting whitespace, sign or digit
    PH_SIGN   = 3'b010,  // a plus sign was seen
    PH_DIGITS = 3'b100   // inside the digits
  } port_phase_e;

  // One input item
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_mark;
  } ipv4v_in_t;

  // One result item
  typedef struct packed {
    logic        valid_res;
    logic        has_port;
    logic [7:0]  octet_a;
    logic [7:0]  octet_b;
    logic [7:0]  octet_c;
    logic [7:0]  octet_d;
    logic [15:0] port_number;
  } ipv4v_res_t;

endpackage

`default_nettype wire

// ===== design/ipv4_port_text_validator.sv =====
// ----------------------------------------------------------------------------
// ipv4_port_text_validator
// Character-stream parser that checks an IPv4 dotted quad with optional
// ":port" and returns the octets and port on each end marker.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (ipv4v_in_t)
//  out     | output    | out_valid_o / out_ready_i | out_data_o (ipv4v_res_t)
//
//  One character per cycle: a transfer lands in the input register, and the
//  next cycle updates the parser state (digit accumulate and compare).
//  An end-marker transfer loads the result register and clears the parser.
//  out_valid_o is the registered valid bit of the result register.
//  Only an end marker waiting on a full, stalled result register holds off
//  new input; characters keep flowing while a result waits.
//  Reset clears the parser to the empty-text state.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_port_text_validator (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire ipv4v_pkg::ipv4v_in_t   in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output ipv4v_pkg::ipv4v_res_t       out_data_o
);
  import ipv4v_pkg::*;

  // Input register
  logic      in_valid_q, in_valid_d;
  ipv4v_in_t in_q;

  // Parser state
  logic        in_port_q,   in_port_d;
  logic [1:0]  group_idx_q, group_idx_d;
  logic [1:0]  digits_q,    digits_d;
  logic [9:0]  group_val_q, group_val_d;
  logic [7:0]  octet_q [3];
  logic [7:0]  octet_d [3];
  port_phase_e phase_q,     phase_d;
  logic [16:0] port_val_q,  port_val_d;
  logic        error_q,     error_d;
  logic        any_char_q,  any_char_d;

  // Result register
  logic       out_valid_q, out_valid_d;
  ipv4v_res_t out_q, out_d;

  // Datapath helpers
  logic       advance;
  logic       out_free;
  logic [7:0] c;
  logic [3:0] dig;
  logic       is_digit;
  logic       is_space;
  logic       addr_ok;
  logic       ok;
  logic [19:0] port_mul;
  logic [16:0] port_next;
  logic [9:0]  group_next;

  // Handshake: process the held character unless an end marker meets a
  // stalled result register
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!in_q.end_mark || out_free);
  assign in_ready_o = !in_valid_q || advance;

  // Classify the character
  assign c        = in_q.char_code;
  assign dig      = c[3:0];
  assign is_digit = (c >= CharZero) && (c <= CharNine);
  assign is_space = (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));

  // Accumulate group and port values
  assign group_next = 10'(group_val_q * 10'd10) + {6'd0, dig};
  assign port_mul   = 20'({3'd0, port_val_q} * 20'd10) + {16'd0, dig};
  assign port_next  = (port_mul > PortMax) ? PortSat : port_mul[16:0];

  // Address part closes as a valid quad
  assign addr_ok = (digits_q != 2'd0) && (group_idx_q == LastGroup) &&
                   (group_val_q <= OctetMax);

  // Verdict at the end marker
  always_comb begin
    ok = any_char_q && !error_q;
    if (ok) begin
      if (in_port_q) begin
        ok = (phase_q == PH_DIGITS) && (port_val_q != 17'd0) &&
             (port_val_q <= PortMax[16:0]);
      end else begin
        ok = addr_ok;
      end
    end
  end

  // Next parser state
  always_comb begin
    in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
    in_port_d   = in_port_q;
    group_idx_d = group_idx_q;
    digits_d    = digits_q;
    group_val_d = group_val_q;
    octet_d     = octet_q;
    phase_d     = phase_q;
    port_val_d  = port_val_q;
    error_d     = error_q;
    any_char_d  = any_char_q;

    if (advance) begin
      if (in_q.end_mark) begin
        // Drop all parse state for the next text
        in_port_d   = 1'b0;
        group_idx_d = 2'd0;
        digits_d    = 2'd0;
        group_val_d = 10'd0;
        for (int i = 0; i < 3; i++) begin
          octet_d[i] = 8'd0;
        end
        phase_d     = PH_WAIT;
        port_val_d  = 17'd0;
        error_d     = 1'b0;
        any_char_d  = 1'b0;
      end else begin
        any_char_d = 1'b1;
        if (!error_q) begin
          if (in_port_q) begin
            // Port part: whitespace, optional plus, digits
            if (is_digit) begin
              port_val_d = port_next;
              phase_d    = PH_DIGITS;
            end else begin
              unique case (phase_q)
                PH_WAIT: begin
                  if (c == CharPlus) begin
                    phase_d = PH_SIGN;
                  end else if (!is_space) begin
                    error_d = 1'b1;
                  end
                end
                PH_SIGN, PH_DIGITS: begin
                  error_d = 1'b1;
                end
                default: begin
                  error_d = 1'b1;
                end
              endcase
            end
          end else begin
            // Address part: digits, dots, one colon
            priority if (is_digit) begin
              if (digits_q >= MaxDigits) begin
                error_d = 1'b1;
              end else begin
                group_val_d = group_next;
                digits_d    = digits_q + 2'd1;
              end
            end else if (c == CharDot) begin
              if ((digits_q == 2'd0) || (group_idx_q == LastGroup) ||
                  (group_val_q > OctetMax)) begin
                error_d = 1'b1;
              end else begin
                for (int i = 0; i < 3; i++) begin
                  if (group_idx_q == 2'(i)) begin
                    octet_d[i] = group_val_q[7:0];
                  end
                end
                group_idx_d = group_idx_q + 2'd1;
                digits_d    = 2'd0;
                group_val_d = 10'd0;
              end
            end else if (c == CharColon) begin
              if (addr_ok) begin
                in_port_d = 1'b1;
              end else begin
                error_d = 1'b1;
              end
            end else begin
              error_d = 1'b1;
            end
          end
        end
      end
    end
  end

  // Result register next value
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && in_q.end_mark) begin
      out_valid_d       = 1'b1;
      out_d.valid_res   = ok;
      out_d.has_port    = in_port_q;
      out_d.octet_a     = ok ? octet_q[0] : 8'd0;
      out_d.octet_b     = ok ? octet_q[1] : 8'd0;
      out_d.octet_c     = ok ? octet_q[2] : 8'd0;
      out_d.octet_d     = ok ? group_val_q[7:0] : 8'd0;
      out_d.port_number = (ok && in_port_q) ? port_val_q[15:0] : 16'd0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      in_port_q   <= 1'b0;
      group_idx_q <= 2'd0;
      digits_q    <= 2'd0;
      group_val_q <= 10'd0;
      for (int i = 0; i < 3; i++) begin
        octet_q[i] <= 8'd0;
      end
      phase_q     <= PH_WAIT;
      port_val_q  <= 17'd0;
      error_q     <= 1'b0;
      any_char_q  <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      in_port_q   <= in_port_d;
      group_idx_q <= group_idx_d;
      digits_q    <= digits_d;
      group_val_q <= group_val_d;
      octet_q     <= octet_d;
      phase_q     <= phase_d;
      port_val_q  <= port_val_d;
      error_q     <= error_d;
      any_char_q  <= any_char_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Assertions
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.valid_res |->
      (out_q.octet_a == 8'd0) && (out_q.octet_b == 8'd0) &&
      (out_q.octet_c == 8'd0) && (out_q.octet_d == 8'd0) &&
      (out_q.port_number == 16'd0))
    else $error("invalid result carries nonzero fields");

  a_port_needs_colon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.port_number != 16'd0) |->
      out_q.has_port && out_q.valid_res)
    else $error("port reported without valid port part");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && in_q.end_mark && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked end marker");

  a_port_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    port_val_q <= PortSat)
    else $error("port accumulator beyond saturation value");

  a_empty_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digits_q == 2'd0) |-> (group_val_q == 10'd0))
    else $error("empty group holds a value");

endmodule

`default_nettype wire
